/* src/tts_pkg.sv */
package tts_pkg;

    // Table size and counter width
    localparam int NUM_TASKS  = 8;
    localparam int COUNT_BITS = 16;
    localparam int TASK_BITS  = $clog2(NUM_TASKS);
    // Compare key must hold the shortest-job limit as well as any counter
    localparam int KEY_BITS   = (COUNT_BITS > 17) ? COUNT_BITS : 17;

    localparam int IDX_BITS   = 6;
    localparam int PRIO_BITS  = 16;
    localparam int FIELD_BITS = 16;

    localparam logic [KEY_BITS-1:0] SJF_LIMIT = KEY_BITS'(100000);
    localparam logic [15:0]         LFSR_TAPS = 16'hB400;

    // Configuration register indexes
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 16;
    localparam logic [CFG_IDX_BITS-1:0] REG_SCHED_MODE  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_REFILL_SEED = 1'b1;

    // Scheduling modes and item kinds
    localparam logic MODE_SJF  = 1'b0;
    localparam logic KIND_LOAD = 1'b1;

    typedef struct packed {
        logic                   kind;
        logic [IDX_BITS-1:0]    task_index;
        logic [PRIO_BITS-1:0]   task_priority;
        logic [FIELD_BITS-1:0]  task_counter;
        logic                   task_runnable;
    } t_in_beat;

    typedef struct packed {
        logic [IDX_BITS-1:0]    running_task;
        logic                   switched;
        logic                   refilled;
        logic                   none_ready;
        logic [FIELD_BITS-1:0]  running_counter;
    } t_out_beat;

    // Static part of a task entry
    typedef struct packed {
        logic [PRIO_BITS-1:0]   prio;
        logic                   rdy;
    } t_attr;

    // Galois LFSR step, zero state forced to one first
    function automatic logic [15:0] lfsr_next(input logic [15:0] cur);
        logic [15:0] v;
        v = (cur == 16'd0) ? 16'd1 : cur;
        if (v[0]) begin
            lfsr_next = (v >> 1) ^ LFSR_TAPS;
        end else begin
            lfsr_next = v >> 1;
        end
    endfunction

endpackage

/* src/tts_in_if.sv */
interface tts_in_if import tts_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/tts_out_if.sv */
interface tts_out_if import tts_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/tick_task_scheduler_top.sv */
// Tick driven task scheduler, shortest job first or highest priority first.
// Input channel i_in carries one beat per item: a timer tick or a load of one
// task entry. Output channel o_out returns exactly one beat per item with the
// running task, its counter and the switched / refilled / none_ready flags.
// Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data):
// index 0 selects the rule, index 1 loads the refill LFSR seed.
// A load or a tick that only decrements goes from accept straight to S_DONE.
// A tick that schedules walks the task table in memories with one write port
// and one registered read port, one entry per cycle: one pass, or two when
// all counters get refilled (the refill pass rescans as it writes). One item
// is in work at a time; the next is accepted once the previous result sits
// in the output register, even if not yet taken.
// When o_out stalls the result is held and a finished item waits for the
// output register to free up. Synchronous reset brings idle (task 0) in as
// the running task, all counters and priorities to zero, all tasks runnable
// and the LFSR to 1; table entries not yet written read as those values.
module tick_task_scheduler_top import tts_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    tts_in_if.sink                   i_in,
    tts_out_if.source                o_out,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_REFILL, S_DONE} t_state;

    localparam logic [TASK_BITS-1:0] FIRST_TASK = TASK_BITS'(1);
    localparam logic [TASK_BITS-1:0] LAST_TASK  = TASK_BITS'(NUM_TASKS - 1);

    t_state r_state;

    // Task table: counters and attributes in two memories
    logic [COUNT_BITS-1:0] cnt_mem  [NUM_TASKS];
    t_attr                 attr_mem [NUM_TASKS];
    logic [NUM_TASKS-1:0]  r_cnt_vld;
    logic [NUM_TASKS-1:0]  r_attr_vld;

    logic [COUNT_BITS-1:0] r_rd_cnt;
    t_attr                 r_rd_attr;
    logic                  r_rd_cnt_vld;
    logic                  r_rd_attr_vld;
    logic [TASK_BITS-1:0]  r_rd_idx;
    logic                  r_rd_on;

    logic [TASK_BITS-1:0]  r_iss_idx;
    logic                  r_iss_on;

    logic                  r_mode;
    logic [15:0]           r_lfsr;
    logic [TASK_BITS-1:0]  r_cur;
    logic [COUNT_BITS-1:0] r_cur_cnt;

    logic [KEY_BITS-1:0]   r_best;
    logic [TASK_BITS-1:0]  r_pick;
    logic [COUNT_BITS-1:0] r_pick_cnt;

    t_out_beat             r_res;
    t_out_beat             r_out;
    logic                  r_out_vld;

    // Write port
    logic                  cnt_we;
    logic                  attr_we;
    logic [TASK_BITS-1:0]  wr_addr;
    logic [COUNT_BITS-1:0] cnt_wd;

    logic                  in_fire;
    logic                  ld_ok;
    logic [TASK_BITS-1:0]  ld_addr;
    logic [COUNT_BITS-1:0] ld_cnt;
    logic [COUNT_BITS-1:0] n_dec;
    logic [15:0]           n_lfsr;
    logic [COUNT_BITS-1:0] refill_val;
    t_attr                 eval_attr;
    logic [COUNT_BITS-1:0] eval_cnt;
    logic                  cand;
    logic [TASK_BITS-1:0]  pick_fin;
    logic [COUNT_BITS-1:0] pick_cnt_fin;
    logic                  scan_end;
    logic [KEY_BITS-1:0]   best_init;

    assign i_in.ready  = (r_state == S_IDLE);
    assign in_fire     = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

    // Decode a load beat
    assign ld_ok   = (i_in.data.kind == KIND_LOAD) && (i_in.data.task_index != '0)
                     && (32'(i_in.data.task_index) < NUM_TASKS);
    assign ld_addr = TASK_BITS'(i_in.data.task_index);
    assign ld_cnt  = COUNT_BITS'(i_in.data.task_counter);

    // Saturating decrement of the running counter
    assign n_dec = (r_cur_cnt != '0) ? r_cur_cnt - COUNT_BITS'(1) : '0;

    // Evaluate the entry that came back from memory
    assign n_lfsr     = lfsr_next(r_lfsr);
    assign eval_attr  = r_rd_attr_vld ? r_rd_attr : t_attr'{prio: '0, rdy: 1'b1};
    assign refill_val = (r_mode == MODE_SJF) ? COUNT_BITS'(n_lfsr)
                                             : COUNT_BITS'(eval_attr.prio);
    assign eval_cnt   = (r_state == S_REFILL) ? refill_val
                      : (r_rd_cnt_vld ? r_rd_cnt : '0);
    assign best_init  = (r_mode == MODE_SJF) ? SJF_LIMIT : '0;

    always_comb begin
        cand = 1'b0;
        if (r_rd_on && eval_attr.rdy && (eval_cnt != '0)) begin
            if (r_mode == MODE_SJF) begin
                cand = KEY_BITS'(eval_cnt) < r_best;
            end else begin
                cand = KEY_BITS'(eval_attr.prio) > r_best;
            end
        end
    end

    assign pick_fin     = cand ? r_rd_idx : r_pick;
    assign pick_cnt_fin = cand ? eval_cnt : r_pick_cnt;
    assign scan_end     = r_rd_on && (r_rd_idx == LAST_TASK);

    // Select the single write into the table
    always_comb begin
        cnt_we  = 1'b0;
        attr_we = 1'b0;
        wr_addr = r_cur;
        cnt_wd  = n_dec;
        if (in_fire && ld_ok) begin
            cnt_we  = 1'b1;
            attr_we = 1'b1;
            wr_addr = ld_addr;
            cnt_wd  = ld_cnt;
        end else if (in_fire && (i_in.data.kind != KIND_LOAD) && (r_cur != '0)) begin
            cnt_we  = 1'b1;
        end else if ((r_state == S_REFILL) && r_rd_on) begin
            cnt_we  = 1'b1;
            wr_addr = r_rd_idx;
            cnt_wd  = refill_val;
        end
    end

    // Table memories with registered read
    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            cnt_mem[wr_addr] <= cnt_wd;
        end
        if (attr_we) begin
            attr_mem[wr_addr] <= '{prio: i_in.data.task_priority,
                                   rdy: i_in.data.task_runnable};
        end
        r_rd_cnt  <= cnt_mem[r_iss_idx];
        r_rd_attr <= attr_mem[r_iss_idx];
    end

    // Sequencer, valid bits and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cnt_vld     <= '0;
            r_attr_vld    <= '0;
            r_rd_cnt_vld  <= 1'b0;
            r_rd_attr_vld <= 1'b0;
            r_rd_on       <= 1'b0;
            r_iss_on      <= 1'b0;
            r_iss_idx     <= FIRST_TASK;
            r_mode        <= MODE_SJF;
            r_lfsr        <= 16'd1;
            r_cur         <= '0;
            r_cur_cnt     <= '0;
            r_out_vld     <= 1'b0;
        end else begin
            r_rd_cnt_vld  <= r_cnt_vld[r_iss_idx];
            r_rd_attr_vld <= r_attr_vld[r_iss_idx];
            r_rd_idx      <= r_iss_idx;
            r_rd_on       <= r_iss_on && ((r_state == S_SCAN) || (r_state == S_REFILL));

            if (cnt_we) begin
                r_cnt_vld[wr_addr] <= 1'b1;
            end
            if (attr_we) begin
                r_attr_vld[wr_addr] <= 1'b1;
            end

            // Configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_SCHED_MODE:  r_mode <= i_cfg_data[0];
                    REG_REFILL_SEED: r_lfsr <= i_cfg_data;
                endcase
            end

            // Load a finished result, drop the output beat once taken
            if ((r_state == S_DONE) && (!r_out_vld || o_out.ready)) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && o_out.ready) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_res.switched   <= 1'b0;
                        r_res.refilled   <= 1'b0;
                        r_res.none_ready <= 1'b0;
                        r_res.running_task <= IDX_BITS'(r_cur);
                        if (i_in.data.kind == KIND_LOAD) begin
                            // Load: counter of the running task may change
                            if (ld_ok && (ld_addr == r_cur)) begin
                                r_cur_cnt <= ld_cnt;
                                r_res.running_counter <= FIELD_BITS'(ld_cnt);
                            end else begin
                                r_res.running_counter <= FIELD_BITS'(r_cur_cnt);
                            end
                            r_state <= S_DONE;
                        end else if ((r_cur != '0) && (n_dec != '0)) begin
                            // Tick with time left: keep the task
                            r_cur_cnt <= n_dec;
                            r_res.running_counter <= FIELD_BITS'(n_dec);
                            r_state <= S_DONE;
                        end else begin
                            // Tick that needs a new pick: start the scan
                            r_cur_cnt <= n_dec;
                            r_iss_idx <= FIRST_TASK;
                            r_iss_on  <= 1'b1;
                            r_best    <= best_init;
                            r_pick    <= '0;
                            r_pick_cnt <= '0;
                            r_state   <= S_SCAN;
                        end
                    end
                end
                S_SCAN, S_REFILL: begin
                    // Advance the read pointer
                    if (r_iss_on) begin
                        if (r_iss_idx == LAST_TASK) begin
                            r_iss_on <= 1'b0;
                        end else begin
                            r_iss_idx <= r_iss_idx + TASK_BITS'(1);
                        end
                    end
                    // Step the LFSR once per refilled entry in shortest-job mode
                    if ((r_state == S_REFILL) && r_rd_on && (r_mode == MODE_SJF)) begin
                        r_lfsr <= n_lfsr;
                    end
                    if (cand) begin
                        r_pick     <= r_rd_idx;
                        r_pick_cnt <= eval_cnt;
                        r_best     <= (r_mode == MODE_SJF) ? KEY_BITS'(eval_cnt)
                                                           : KEY_BITS'(eval_attr.prio);
                    end
                    if (scan_end) begin
                        if (pick_fin != '0) begin
                            r_cur     <= pick_fin;
                            r_cur_cnt <= pick_cnt_fin;
                            r_res.running_task    <= IDX_BITS'(pick_fin);
                            r_res.running_counter <= FIELD_BITS'(pick_cnt_fin);
                            r_res.switched        <= (pick_fin != r_cur);
                            r_state <= S_DONE;
                        end else if (r_state == S_SCAN) begin
                            // Nothing qualifies: refill and rescan in one pass
                            r_iss_idx  <= FIRST_TASK;
                            r_iss_on   <= 1'b1;
                            r_best     <= best_init;
                            r_pick     <= '0;
                            r_pick_cnt <= '0;
                            r_res.refilled <= 1'b1;
                            r_state    <= S_REFILL;
                        end else begin
                            r_cur     <= '0;
                            r_cur_cnt <= '0;
                            r_res.running_task    <= '0;
                            r_res.running_counter <= '0;
                            r_res.switched        <= (r_cur != '0);
                            r_res.none_ready      <= 1'b1;
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    // Hand the result over once the output register is free
                    if (!r_out_vld || o_out.ready) begin
                        r_out     <= r_res;
                        r_state   <= S_IDLE;
                    end
                end
            endcase
        end
    end

    // An accepted item always leaves the idle state for work
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state != S_IDLE))
        else $error("item accepted without entering work");

    // No qualifying task leaves idle running and implies a refill
    a_none_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.none_ready) |-> (r_out.running_task == '0) && r_out.refilled)
        else $error("none_ready result with a running task");

    // Idle always reports a zero counter
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur == '0) |-> (r_cur_cnt == '0))
        else $error("idle task with nonzero counter");

    // A result never switches to a task that has no time left
    a_switch_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.switched && (r_out.running_task != '0))
            |-> (r_out.running_counter != '0) || (COUNT_BITS > FIELD_BITS))
        else $error("switched to a task with zero counter");

endmodule
